// ===== hdl/radix2_complex_fft_macros.svh =====
`ifndef RADIX2_COMPLEX_FFT_MACROS_SVH
`define RADIX2_COMPLEX_FFT_MACROS_SVH

// Concurrent checks on the rising edge of clk, switched off while arst_n is low.
// The consequent is checked in the cycle after the antecedent.
`define R2FFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("r2fft check failed");

// The consequent is checked in the same cycle as the antecedent.
`define R2FFT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("r2fft check failed");

`endif

// ===== hdl/r2fft_pkg.sv =====
`timescale 1ns / 1ps

package r2fft_pkg;

	localparam int MAX_ORDER_DEF    = 10;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// Twiddle angles are pi * a / 2^ANG_BITS; twiddles are Q1.15.
	localparam int ANG_BITS = 14;
	localparam int TW_WIDTH = 16;

	localparam int ORDER_W = 4;
	localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd10;

	localparam int ACT_W = 2;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	// Register select is address bit 2.
	localparam logic REG_ORDER   = 1'b0;
	localparam logic REG_INVERSE = 1'b1;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 2'd0,
		ACT_RUN   = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef struct packed {
		logic [ORDER_W-1:0] order;
		logic               inverse;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_REV_RD,
		ST_REV_WA,
		ST_REV_WB,
		ST_BF_RD,
		ST_BF_MUL,
		ST_BF_SUM,
		ST_BF_WZ,
		ST_BF_WK
	} eng_state_t;

endpackage

// ===== hdl/r2fft_ram.sv =====
`timescale 1ns / 1ps

module r2fft_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

// ===== hdl/r2fft_front.sv =====
`timescale 1ns / 1ps

module r2fft_front #(
	parameter int MAX_ORDER    = r2fft_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             s_tvalid,
	output logic                                             s_tready,
	input  logic [((MAX_ORDER+2*SAMPLE_WIDTH+7)/8)*8-1:0]    s_tdata,
	input  logic [r2fft_pkg::ACT_W-1:0]                      s_tuser,
	output logic                                             cmd_valid,
	input  logic                                             cmd_ready,
	output logic [r2fft_pkg::ACT_W+MAX_ORDER+2*SAMPLE_WIDTH-1:0] cmd
);

	import r2fft_pkg::*;

	localparam int PAY_W  = MAX_ORDER + 2 * SAMPLE_WIDTH;
	localparam int CMD_W  = ACT_W + PAY_W;
	localparam int QDEPTH = 2;

	logic [CMD_W-1:0] ent_q [QDEPTH];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       cnt_q;
	logic             known;
	logic             push;
	logic             pop;

	// Undefined action codes are taken and dropped here.
	always_comb begin
		case (action_t'(s_tuser))
			ACT_WRITE, ACT_RUN, ACT_READ: known = 1'b1;
			default:                      known = 1'b0;
		endcase
	end

	assign s_tready  = (cnt_q != 2'(QDEPTH));
	assign push      = s_tvalid && s_tready && known;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= {s_tdata[PAY_W-1:0], s_tuser};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hdl/r2fft_engine.sv =====
`timescale 1ns / 1ps

module r2fft_engine #(
	parameter int MAX_ORDER    = r2fft_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  r2fft_pkg::cfg_t                                      cfg,
	input  logic                                                 cmd_valid,
	output logic                                                 cmd_ready,
	input  logic [r2fft_pkg::ACT_W+MAX_ORDER+2*SAMPLE_WIDTH-1:0] cmd,
	output logic                                                 m_tvalid,
	input  logic                                                 m_tready,
	output logic [SAMPLE_WIDTH+MAX_ORDER+1:0]                    bin_re,
	output logic [SAMPLE_WIDTH+MAX_ORDER+1:0]                    bin_im
);

	import r2fft_pkg::*;

	localparam int AW  = MAX_ORDER;
	localparam int SW  = SAMPLE_WIDTH;
	localparam int STW = SW + MAX_ORDER + 2;
	localparam int DW  = 2 * STW;
	localparam int PW  = STW + TW_WIDTH;

	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam int TW_SHIFT = ANG_BITS + 1 - MAX_ORDER;
	localparam int TW_DEPTH = ((1 << (ANG_BITS - 2)) >> TW_SHIFT) + 1;
	localparam int TW_IW    = (TW_DEPTH > 1) ? $clog2(TW_DEPTH) : 1;

	localparam logic [ANG_BITS-1:0] ANG_HALF    = ANG_BITS'(1) << (ANG_BITS - 1);
	localparam logic [ANG_BITS-1:0] ANG_QUARTER = ANG_BITS'(1) << (ANG_BITS - 2);
	localparam logic [PW:0]         RND_HALF    = (PW + 1)'(1) << 14;

	typedef logic [TW_DEPTH-1:0][2*TW_WIDTH-1:0] tw_tab_t;

	// Unsigned long division, only evaluated while the twiddle table is built.
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = 0;
		r = 0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], num[b]};
			if (r >= den) begin
				r = r - den;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Cosine and sine for angle pi*a/2^ANG_BITS in the first octant: Taylor sums
	// in Q2.30, rounded half up to Q1.15 and saturated. Cosine is the upper half.
	function automatic logic [2*TW_WIDTH-1:0] base_trig(input longint unsigned a);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint          ss;
		longint          cs;
		x  = (a * PI_Q30) >> ANG_BITS;
		x2 = (x * x) >> 30;
		ts = x;
		tc = 64'd1 << 30;
		ss = 0;
		cs = 0;
		for (int n = 0; n < 8; n++) begin
			if (n[0]) begin
				ss = ss - longint'(ts);
				cs = cs - longint'(tc);
			end else begin
				ss = ss + longint'(ts);
				cs = cs + longint'(tc);
			end
			ts = udiv((ts * x2) >> 30, 64'((2 * n + 2) * (2 * n + 3)));
			tc = udiv((tc * x2) >> 30, 64'((2 * n + 1) * (2 * n + 2)));
		end
		ss = (ss + 16384) >>> 15;
		cs = (cs + 16384) >>> 15;
		if (ss > 32767) begin
			ss = 32767;
		end
		if (cs > 32767) begin
			cs = 32767;
		end
		return {cs[TW_WIDTH-1:0], ss[TW_WIDTH-1:0]};
	endfunction

	function automatic tw_tab_t build_tw();
		tw_tab_t t;
		for (int e = 0; e < TW_DEPTH; e++) begin
			t[e] = base_trig(longint'(e) << TW_SHIFT);
		end
		return t;
	endfunction

	localparam tw_tab_t TW_ROM = build_tw();

	eng_state_t state_q, state_d;

	logic [AW-1:0]      i_q, i_d;
	logic [ORDER_W-1:0] s0_q, s0_d;

	// Command fields.
	action_t               c_act;
	logic [AW-1:0]         c_idx;
	logic [SW-1:0]         c_re;
	logic [SW-1:0]         c_im;

	logic [ORDER_W-1:0]    ord;
	logic [ORDER_W-1:0]    rsh;
	logic [AW-1:0]         nmask;
	logic [AW-1:0]         rev_full;
	logic [AW-1:0]         rev;
	logic                  last_i;
	logic                  last_b;

	logic [AW-1:0]         n_bit;
	logic [AW-1:0]         lowm;
	logic [AW-1:0]         bf_k;
	logic [AW-1:0]         bf_z;
	logic [AW+ANG_BITS-1:0] ang_ext;
	logic [ANG_BITS-1:0]   ang;
	logic [ANG_BITS-1:0]   a1;
	logic [ANG_BITS-1:0]   a2;
	logic                  neg_c;
	logic                  swap;
	logic [TW_IW-1:0]      tw_idx;
	logic [2*TW_WIDTH-1:0] tw_ent;
	logic signed [TW_WIDTH-1:0] bc, bs, wc, ws;

	// Store port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr_a;
	logic [AW-1:0] ram_raddr_b;
	logic [DW-1:0] ram_rdata_a;
	logic [DW-1:0] ram_rdata_b;

	logic out_free;
	logic out_ld;

	// Datapath registers.
	logic [DW-1:0]              hold_q;
	logic signed [TW_WIDTH-1:0] wc_q, ws_q;
	logic signed [PW-1:0]       p_rc_q, p_is_q, p_ic_q, p_rs_q;
	logic [STW-1:0]             kr_q, ki_q, tr_q, ti_q;
	logic signed [STW-1:0]      zr, zi;
	logic [PW:0]                sum_r, sum_i;
	logic                       out_valid_q;
	logic [DW-1:0]              out_data_q;

	assign c_act = action_t'(cmd[ACT_W-1:0]);
	assign c_idx = cmd[ACT_W+AW-1:ACT_W];
	assign c_re  = cmd[ACT_W+AW+SW-1:ACT_W+AW];
	assign c_im  = cmd[ACT_W+AW+2*SW-1:ACT_W+AW+SW];

	assign ord   = (cfg.order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : cfg.order;
	assign nmask = ~({AW{1'b1}} << ord);
	assign rsh   = ORDER_W'(AW) - ord;

	always_comb begin
		rev_full = '0;
		for (int p = 0; p < AW; p++) begin
			rev_full[AW-1-p] = i_q[p];
		end
	end

	assign rev    = rev_full >> rsh;
	assign last_i = (i_q == nmask);
	assign last_b = (i_q == (nmask >> 1));

	// Butterfly number i_q in stage s0_q: spread a zero into bit s0_q.
	assign n_bit = AW'(1) << s0_q;
	assign lowm  = n_bit - AW'(1);
	assign bf_k  = ((i_q & ~lowm) << 1) | (i_q & lowm);
	assign bf_z  = bf_k | n_bit;

	assign ang_ext = {i_q & lowm, {ANG_BITS{1'b0}}} >> s0_q;
	assign ang     = ang_ext[ANG_BITS-1:0];

	// Fold the angle into the first octant, look up, then unfold.
	always_comb begin
		neg_c = (ang > ANG_HALF);
		a1    = neg_c ? (~ang + ANG_BITS'(1)) : ang;
		swap  = (a1 > ANG_QUARTER);
		a2    = swap ? (ANG_HALF - a1) : a1;
	end

	assign tw_idx = TW_IW'(a2 >> TW_SHIFT);
	assign tw_ent = TW_ROM[tw_idx];
	assign bc     = swap ? tw_ent[TW_WIDTH-1:0] : tw_ent[2*TW_WIDTH-1:TW_WIDTH];
	assign bs     = swap ? tw_ent[2*TW_WIDTH-1:TW_WIDTH] : tw_ent[TW_WIDTH-1:0];
	assign wc     = neg_c ? -bc : bc;
	assign ws     = cfg.inverse ? -bs : bs;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d     = state_q;
		i_d         = i_q;
		s0_d        = s0_q;
		cmd_ready   = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = bf_k;
		ram_wdata   = {ki_q + ti_q, kr_q + tr_q};
		ram_raddr_a = bf_k;
		ram_raddr_b = bf_z;
		out_ld      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					case (c_act)
						ACT_WRITE: begin
							cmd_ready = 1'b1;
							ram_we    = 1'b1;
							ram_waddr = c_idx;
							ram_wdata = {{(STW-SW){c_im[SW-1]}}, c_im,
								{(STW-SW){c_re[SW-1]}}, c_re};
						end
						ACT_RUN: begin
							cmd_ready = 1'b1;
							i_d       = '0;
							s0_d      = '0;
							if (ord != '0) begin
								state_d = ST_REV_RD;
							end
						end
						ACT_READ: begin
							if (out_free) begin
								cmd_ready   = 1'b1;
								ram_raddr_a = c_idx;
								state_d     = ST_RD_WAIT;
							end
						end
						default: begin
							cmd_ready = 1'b1;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				out_ld  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_REV_RD, ST_REV_WB: begin
				ram_raddr_a = i_q;
				ram_raddr_b = rev;
				if (state_q == ST_REV_WB) begin
					ram_we    = 1'b1;
					ram_waddr = rev;
					ram_wdata = hold_q;
				end
				if (state_q == ST_REV_RD && i_q < rev) begin
					state_d = ST_REV_WA;
				end else if (last_i) begin
					i_d     = '0;
					s0_d    = '0;
					state_d = ST_BF_RD;
				end else begin
					i_d     = i_q + AW'(1);
					state_d = ST_REV_RD;
				end
			end
			ST_REV_WA: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata_b;
				state_d   = ST_REV_WB;
			end
			ST_BF_RD: begin
				state_d = ST_BF_MUL;
			end
			ST_BF_MUL: begin
				state_d = ST_BF_SUM;
			end
			ST_BF_SUM: begin
				state_d = ST_BF_WZ;
			end
			ST_BF_WZ: begin
				ram_we    = 1'b1;
				ram_waddr = bf_z;
				ram_wdata = {ki_q - ti_q, kr_q - tr_q};
				state_d   = ST_BF_WK;
			end
			ST_BF_WK: begin
				ram_we  = 1'b1;
				state_d = ST_BF_RD;
				if (last_b) begin
					i_d = '0;
					if (s0_q == ord - ORDER_W'(1)) begin
						state_d = ST_IDLE;
					end else begin
						s0_d = s0_q + ORDER_W'(1);
					end
				end else begin
					i_d = i_q + AW'(1);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			s0_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			s0_q    <= s0_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign zr    = ram_rdata_b[STW-1:0];
	assign zi    = ram_rdata_b[DW-1:STW];
	assign sum_r = {p_rc_q[PW-1], p_rc_q} + {p_is_q[PW-1], p_is_q} + RND_HALF;
	assign sum_i = {p_ic_q[PW-1], p_ic_q} - {p_rs_q[PW-1], p_rs_q} + RND_HALF;

	always_ff @(posedge clk) begin
		if (state_q == ST_REV_WA) begin
			hold_q <= ram_rdata_a;
		end
		if (state_q == ST_BF_RD) begin
			wc_q <= wc;
			ws_q <= ws;
		end
		if (state_q == ST_BF_MUL) begin
			p_rc_q <= zr * wc_q;
			p_is_q <= zi * ws_q;
			p_ic_q <= zi * wc_q;
			p_rs_q <= zr * ws_q;
			kr_q   <= ram_rdata_a[STW-1:0];
			ki_q   <= ram_rdata_a[DW-1:STW];
		end
		if (state_q == ST_BF_SUM) begin
			// Floor shift by 15 after the half-LSB offset: round half up.
			tr_q <= sum_r[STW+14:15];
			ti_q <= sum_i[STW+14:15];
		end
		if (out_ld) begin
			out_data_q <= ram_rdata_a;
		end
	end

	assign m_tvalid = out_valid_q;
	assign bin_re   = out_data_q[STW-1:0];
	assign bin_im   = out_data_q[DW-1:STW];

	r2fft_ram #(
		.WIDTH(DW),
		.DEPTH(1 << AW)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

endmodule

// ===== hdl/radix2_complex_fft.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Contents
// s_        in         s_tvalid/s_tready  one command beat: action, index, sample
// m_        out        m_tvalid/m_tready  one bin beat for each read command
// apb       in/out     psel/penable       fft_order and inverse registers
//
// A write command is done in the engine's idle state, and a read passes through
// a wait state that loads the bin; a two-entry command queue sits in front of
// the engine, so beats arrive while it works. A run walks every index for bit
// reversal, swapping each pair in two writes, then steps each butterfly through
// read, multiply, sum and two writes on the single store memory's one write port.
// Reset clears control state only; the store holds garbage until written.
// A read waits while the output register holds a bin that has not been taken.

module radix2_complex_fft #(
	parameter int MAX_ORDER    = r2fft_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic                                               s_tvalid,
	output logic                                               s_tready,
	// index, sample_re, sample_im from bit 0 up, zero padded to bytes
	input  logic [((MAX_ORDER+2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
	// action
	input  logic [r2fft_pkg::ACT_W-1:0]                        s_tuser,
	output logic                                               m_tvalid,
	input  logic                                               m_tready,
	// bin_re, bin_im from bit 0 up, zero padded to bytes
	output logic [((2*(SAMPLE_WIDTH+MAX_ORDER+2)+7)/8)*8-1:0]  m_tdata,
	input  logic                                               psel,
	input  logic                                               penable,
	input  logic                                               pwrite,
	input  logic [r2fft_pkg::APB_AW-1:0]                       paddr,
	input  logic [r2fft_pkg::APB_DW-1:0]                       pwdata,
	output logic [r2fft_pkg::APB_DW-1:0]                       prdata,
	output logic                                               pready
);

	import r2fft_pkg::*;

	localparam int STW    = SAMPLE_WIDTH + MAX_ORDER + 2;
	localparam int OUT_TW = ((2 * STW + 7) / 8) * 8;
	localparam int CMD_W  = ACT_W + MAX_ORDER + 2 * SAMPLE_WIDTH;

	cfg_t             cfg_q;
	logic             cfg_wr;
	logic             cmd_valid;
	logic             cmd_ready;
	logic [CMD_W-1:0] cmd;
	logic [STW-1:0]   bin_re;
	logic [STW-1:0]   bin_im;

	// The user must change the configuration registers only while the block is idle;
	// the block does not enforce this, and the engine reads them straight from these flops.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order   <= ORDER_RESET;
			cfg_q.inverse <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_ORDER:   cfg_q.order   <= pwdata[ORDER_W-1:0];
				REG_INVERSE: cfg_q.inverse <= pwdata[0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ORDER:   prdata = APB_DW'(cfg_q.order);
			REG_INVERSE: prdata = APB_DW'(cfg_q.inverse);
			default:     prdata = '0;
		endcase
	end

	// The front classifies beats and queues the valid commands.
	r2fft_front #(
		.MAX_ORDER   (MAX_ORDER),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd)
	);

	// The engine owns the sample store and runs writes, reads and transforms.
	r2fft_engine #(
		.MAX_ORDER   (MAX_ORDER),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.bin_re   (bin_re),
		.bin_im   (bin_im)
	);

	assign m_tdata = OUT_TW'({bin_im, bin_re});

endmodule

// ===== hdl/r2fft_checker.sv =====
`timescale 1ns / 1ps
`include "radix2_complex_fft_macros.svh"

module r2fft_checker #(
	parameter int MAX_ORDER    = r2fft_pkg::MAX_ORDER_DEF,
	parameter int SAMPLE_WIDTH = r2fft_pkg::SAMPLE_WIDTH_DEF
) (
	input logic                                               clk,
	input logic                                               arst_n,
	input logic                                               s_tvalid,
	input logic                                               s_tready,
	input logic [((MAX_ORDER+2*SAMPLE_WIDTH+7)/8)*8-1:0]      s_tdata,
	input logic [r2fft_pkg::ACT_W-1:0]                        s_tuser,
	input logic                                               m_tvalid,
	input logic                                               m_tready,
	input logic [((2*(SAMPLE_WIDTH+MAX_ORDER+2)+7)/8)*8-1:0]  m_tdata,
	input logic                                               psel,
	input logic                                               penable,
	input logic                                               pwrite,
	input logic [r2fft_pkg::APB_AW-1:0]                       paddr,
	input logic [r2fft_pkg::APB_DW-1:0]                       pwdata,
	input logic [r2fft_pkg::APB_DW-1:0]                       prdata,
	input logic                                               pready
);

	// A stalled bin stays offered and unchanged.
	`R2FFT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
	`R2FFT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))

	// A register write is visible on a read of the same register next cycle.
	`R2FFT_ASSERT_NEXT(a_order_readback, psel && penable && pwrite && pready && !paddr[2], paddr[2] || (prdata[3:0] == $past(pwdata[3:0])))
	`R2FFT_ASSERT_NOW(a_inverse_readback, $past(arst_n && psel && penable && pwrite && pready && paddr[2]), !paddr[2] || (prdata[0] == $past(pwdata[0])))

endmodule

bind radix2_complex_fft r2fft_checker #(
	.MAX_ORDER   (MAX_ORDER),
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_r2fft_checker (.*);
